@@ hdl/hc2_pkg.sv @@
// Shared types, constants and mod-26 helper functions for the 2x2 Hill cipher core.
// Used by hc2_key_prep, hc2_lane and hill_cipher_2x2_pair_core. No dependencies.
package hc2_pkg;

    // Field widths.
    localparam int LETTER_W    = 7;
    localparam int IDX_W       = 5;
    localparam int KEY_W       = 5;
    localparam int PROD_W      = 2 * IDX_W;
    localparam int CFG_INDEX_W = 3;

    // Pipeline layout: key preparation, two lane stages, then the merge stage.
    localparam int KEY_STAGES  = 6;
    localparam int LANE_STAGES = 2;
    localparam int PIPE_DEPTH  = KEY_STAGES + LANE_STAGES + 1;

    // Character codes and the pad letter index.
    localparam logic [LETTER_W-1:0] BASE_CODE = 7'd97;
    localparam logic [LETTER_W-1:0] LAST_CODE = 7'd122;
    localparam logic [IDX_W-1:0]    PAD_INDEX = 5'd23;
    localparam logic [IDX_W-1:0]    ALPHA     = 5'd26;

    // Mode codes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TOP_LEFT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_TOP_RIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BOTTOM_LEFT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BOTTOM_RIGHT = 3'd3;

    // Key matrix as stored in the configuration registers.
    typedef struct packed {
        logic [KEY_W-1:0] top_left;
        logic [KEY_W-1:0] top_right;
        logic [KEY_W-1:0] bottom_left;
        logic [KEY_W-1:0] bottom_right;
    } hc2_key_t;

    // Matrix that the lanes multiply by, plus the non-invertible flag.
    typedef struct packed {
        logic [IDX_W-1:0] m00;
        logic [IDX_W-1:0] m01;
        logic [IDX_W-1:0] m10;
        logic [IDX_W-1:0] m11;
        logic             bad;
    } hc2_matrix_t;

    // Remainder by 26 for values below 2048. The quotient estimate x*157/4096 is
    // never above the true quotient and at most one below it, so one correction step
    // is enough.
    function automatic logic [IDX_W-1:0] mod26(input logic [10:0] x);
        logic [18:0] prod;
        logic [6:0]  q;
        logic [11:0] r;
        prod = {8'd0, x} * 19'd157;
        q    = prod[18:12];
        r    = {1'b0, x} - ({5'd0, q} * 12'd26);
        if (r >= 12'd26)
        begin
            r = r - 12'd26;
        end
        return r[IDX_W-1:0];
    endfunction

    // Letter index of an ASCII code: (code - 97) mod 26, always in 0..25.
    function automatic logic [IDX_W-1:0] letter_index(input logic [LETTER_W-1:0] code);
        return mod26({4'd0, code} + 11'd7);
    endfunction

    // Reduce a 5-bit key entry into 0..25.
    function automatic logic [IDX_W-1:0] reduce_key(input logic [KEY_W-1:0] v);
        return (v >= ALPHA) ? (v - ALPHA) : v;
    endfunction

    // Additive inverse mod 26 of a value in 0..25.
    function automatic logic [IDX_W-1:0] negate26(input logic [IDX_W-1:0] v);
        return (v == 5'd0) ? 5'd0 : (ALPHA - v);
    endfunction

    // Multiplicative inverse mod 26; zero when none exists.
    function automatic logic [IDX_W-1:0] inverse26(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        unique case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/hc2_key_prep.sv @@
// Key preparation pipeline: reduces the key, forms the determinant and its inverse,
// and delivers the encrypt or decrypt matrix through six register stages. Depends on hc2_pkg.
module hc2_key_prep (
    input  logic                                clk,
    input  logic [hc2_pkg::KEY_STAGES-1:0]      load,
    input  hc2_pkg::hc2_key_t                   key,
    input  logic                                mode,
    output hc2_pkg::hc2_matrix_t                matrix
);
    import hc2_pkg::*;

    // Stage 0: key entries reduced to 0..25.
    logic [IDX_W-1:0] a0_reg, b0_reg, c0_reg, d0_reg;
    logic             mode0_reg;

    // Stage 1: cross products for the determinant.
    logic [PROD_W-1:0] ad1_reg, bc1_reg;
    logic [IDX_W-1:0]  a1_reg, b1_reg, c1_reg, d1_reg;
    logic              mode1_reg;

    // Stage 2: determinant mod 26.
    logic [IDX_W-1:0] det2_reg, det2_next;
    logic [IDX_W-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic             mode2_reg;

    // Stage 3: inverse of the determinant and negated off-diagonal entries.
    logic [IDX_W-1:0] inv3_reg, nb3_reg, nc3_reg;
    logic [IDX_W-1:0] a3_reg, b3_reg, c3_reg, d3_reg;
    logic             mode3_reg, bad3_reg;

    // Stage 4: products of the inverse with the adjugate entries.
    logic [PROD_W-1:0] pd4_reg, pnb4_reg, pnc4_reg, pa4_reg;
    logic [IDX_W-1:0]  a4_reg, b4_reg, c4_reg, d4_reg;
    logic              mode4_reg, bad4_reg;

    // Stage 5: final matrix.
    hc2_matrix_t matrix_reg, matrix_next;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a0_reg    <= reduce_key(key.top_left);
            b0_reg    <= reduce_key(key.top_right);
            c0_reg    <= reduce_key(key.bottom_left);
            d0_reg    <= reduce_key(key.bottom_right);
            mode0_reg <= mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            ad1_reg   <= {5'd0, a0_reg} * {5'd0, d0_reg};
            bc1_reg   <= {5'd0, b0_reg} * {5'd0, c0_reg};
            a1_reg    <= a0_reg;
            b1_reg    <= b0_reg;
            c1_reg    <= c0_reg;
            d1_reg    <= d0_reg;
            mode1_reg <= mode0_reg;
        end
    end

    // The offset of 26*26 keeps a*d - b*c non-negative before the reduction.
    always_comb
    begin
        det2_next = mod26({1'b0, ad1_reg} + 11'd676 - {1'b0, bc1_reg});
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            det2_reg  <= det2_next;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            c2_reg    <= c1_reg;
            d2_reg    <= d1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            inv3_reg  <= inverse26(det2_reg);
            bad3_reg  <= (mode2_reg == MODE_DECRYPT) && (inverse26(det2_reg) == 5'd0);
            nb3_reg   <= negate26(b2_reg);
            nc3_reg   <= negate26(c2_reg);
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            c3_reg    <= c2_reg;
            d3_reg    <= d2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            pd4_reg   <= {5'd0, inv3_reg} * {5'd0, d3_reg};
            pnb4_reg  <= {5'd0, inv3_reg} * {5'd0, nb3_reg};
            pnc4_reg  <= {5'd0, inv3_reg} * {5'd0, nc3_reg};
            pa4_reg   <= {5'd0, inv3_reg} * {5'd0, a3_reg};
            a4_reg    <= a3_reg;
            b4_reg    <= b3_reg;
            c4_reg    <= c3_reg;
            d4_reg    <= d3_reg;
            mode4_reg <= mode3_reg;
            bad4_reg  <= bad3_reg;
        end
    end

    // Decrypt uses the reduced inverse-times-adjugate; encrypt uses the reduced key entries directly.
    always_comb
    begin
        if (mode4_reg == MODE_DECRYPT)
        begin
            matrix_next.m00 = mod26({1'b0, pd4_reg});
            matrix_next.m01 = mod26({1'b0, pnb4_reg});
            matrix_next.m10 = mod26({1'b0, pnc4_reg});
            matrix_next.m11 = mod26({1'b0, pa4_reg});
        end
        else
        begin
            matrix_next.m00 = a4_reg;
            matrix_next.m01 = b4_reg;
            matrix_next.m10 = c4_reg;
            matrix_next.m11 = d4_reg;
        end
        matrix_next.bad = bad4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            matrix_reg <= matrix_next;
        end
    end

    assign matrix = matrix_reg;

endmodule

@@ hdl/hc2_lane.sv @@
// One output lane: a row of the matrix times the letter pair, reduced mod 26 and
// mapped back to ASCII over two stages. Depends on hc2_pkg.
module hc2_lane (
    input  logic                                clk,
    input  logic [hc2_pkg::LANE_STAGES-1:0]     load,
    input  logic [hc2_pkg::IDX_W-1:0]           coef0,
    input  logic [hc2_pkg::IDX_W-1:0]           coef1,
    input  logic [hc2_pkg::IDX_W-1:0]           p0,
    input  logic [hc2_pkg::IDX_W-1:0]           p1,
    output logic [hc2_pkg::LETTER_W-1:0]        letter
);
    import hc2_pkg::*;

    logic [PROD_W-1:0]   prod0_reg, prod1_reg;
    logic [LETTER_W-1:0] letter_reg, letter_next;

    // Stage 0: the two products of the row.
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            prod0_reg <= {5'd0, coef0} * {5'd0, p0};
            prod1_reg <= {5'd0, coef1} * {5'd0, p1};
        end
    end

    // Stage 1: sum, reduce and convert to a lower-case letter.
    always_comb
    begin
        letter_next = {2'd0, mod26({1'b0, prod0_reg} + {1'b0, prod1_reg})} + BASE_CODE;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            letter_reg <= letter_next;
        end
    end

    assign letter = letter_reg;

endmodule

@@ hdl/hill_cipher_2x2_pair_core.sv @@
// Nine registers lie between the accepting input edge and out_valid: six
// key-preparation stages, two lane stages and the merge register. Throughput:
// one item per cycle while out_ready is high; each stage has its own valid bit
// and loads when it is empty or its successor is moving, so bubbles are filled
// in a stall. Reset clears all valid bits, loads the identity key; no clearing pass.
module hill_cipher_2x2_pair_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [hc2_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hc2_pkg::KEY_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hc2_pkg::LETTER_W-1:0]        first_letter,
    input  logic [hc2_pkg::LETTER_W-1:0]        second_letter,
    input  logic                                second_absent,
    input  logic                                mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hc2_pkg::LETTER_W-1:0]        out_first,
    output logic [hc2_pkg::LETTER_W-1:0]        out_second,
    output logic                                key_invalid
);
    import hc2_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    hc2_key_t                key_reg;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   stage_ready;
    logic [PIPE_DEPTH-1:0]   stage_vin;
    logic [PIPE_DEPTH-1:0]   load;
    logic [IDX_W-1:0]        p0_reg [KEY_STAGES];
    logic [IDX_W-1:0]        p1_reg [KEY_STAGES];
    logic [IDX_W-1:0]        p1_next;
    hc2_matrix_t             matrix;
    logic                    bad6_reg, bad7_reg;
    logic [LETTER_W-1:0]     lane0_letter, lane1_letter;
    logic [LETTER_W-1:0]     out_first_reg, out_second_reg;
    logic                    key_invalid_reg;

    // Key registers; writes beyond the last index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg.top_left     <= 5'd1;
            key_reg.top_right    <= 5'd0;
            key_reg.bottom_left  <= 5'd0;
            key_reg.bottom_right <= 5'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_TOP_LEFT:     key_reg.top_left     <= cfg_data;
                REG_KEY_TOP_RIGHT:    key_reg.top_right    <= cfg_data;
                REG_KEY_BOTTOM_LEFT:  key_reg.bottom_left  <= cfg_data;
                REG_KEY_BOTTOM_RIGHT: key_reg.bottom_right <= cfg_data;
                default:              key_reg              <= key_reg;
            endcase
        end
    end

    // Ready chain: a stage can take a new item when it is empty or its item moves on.
    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        stage_vin = {valid_reg[LAST-1:0], in_valid};
        load      = stage_ready & stage_vin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= stage_vin[k];
                end
            end
        end
    end

    assign in_ready = stage_ready[0];

    // Letter indices, padded with 'x' for an odd tail, travel beside the key pipeline.
    always_comb
    begin
        p1_next = second_absent ? PAD_INDEX : letter_index(second_letter);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            p0_reg[0] <= letter_index(first_letter);
            p1_reg[0] <= p1_next;
        end
        for (int k = 1; k < KEY_STAGES; k++)
        begin
            if (load[k])
            begin
                p0_reg[k] <= p0_reg[k-1];
                p1_reg[k] <= p1_reg[k-1];
            end
        end
    end

    hc2_key_prep u_key_prep (
        .clk    (clk),
        .load   (load[KEY_STAGES-1:0]),
        .key    (key_reg),
        .mode   (mode),
        .matrix (matrix)
    );

    // One lane per output letter.
    hc2_lane u_lane0 (
        .clk    (clk),
        .load   (load[KEY_STAGES+LANE_STAGES-1:KEY_STAGES]),
        .coef0  (matrix.m00),
        .coef1  (matrix.m01),
        .p0     (p0_reg[KEY_STAGES-1]),
        .p1     (p1_reg[KEY_STAGES-1]),
        .letter (lane0_letter)
    );

    hc2_lane u_lane1 (
        .clk    (clk),
        .load   (load[KEY_STAGES+LANE_STAGES-1:KEY_STAGES]),
        .coef0  (matrix.m10),
        .coef1  (matrix.m11),
        .p0     (p0_reg[KEY_STAGES-1]),
        .p1     (p1_reg[KEY_STAGES-1]),
        .letter (lane1_letter)
    );

    // The invalid flag follows the lanes.
    always_ff @(posedge clk)
    begin
        if (load[KEY_STAGES])
        begin
            bad6_reg <= matrix.bad;
        end
        if (load[KEY_STAGES+1])
        begin
            bad7_reg <= bad6_reg;
        end
    end

    // Merge: a non-invertible key in decrypt replaces both letters with 'a'.
    always_ff @(posedge clk)
    begin
        if (load[LAST])
        begin
            out_first_reg   <= bad7_reg ? BASE_CODE : lane0_letter;
            out_second_reg  <= bad7_reg ? BASE_CODE : lane1_letter;
            key_invalid_reg <= bad7_reg;
        end
    end

    assign out_valid   = valid_reg[LAST];
    assign out_first   = out_first_reg;
    assign out_second  = out_second_reg;
    assign key_invalid = key_invalid_reg;

    // An empty output register means the whole pipeline can take an item.
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output stage is empty");

    // A flagged key always shows 'a' in both letters.
    a_invalid_letters : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_invalid) |-> (out_first == BASE_CODE && out_second == BASE_CODE))
        else $error("invalid key result carries letters other than a");

    // Results are always lower-case letters.
    a_first_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_first >= BASE_CODE && out_first <= LAST_CODE))
        else $error("out_first outside a..z");

    a_second_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_second >= BASE_CODE && out_second <= LAST_CODE))
        else $error("out_second outside a..z");

endmodule
